[hdl/bhoe_pkg.sv]
// Shared types and constants for the backend health and outlier ejection unit.
`default_nettype none
package bhoe_pkg;

  localparam int NUM_BACKENDS = 64;
  localparam int IDX_W = $clog2(NUM_BACKENDS);

  typedef enum logic [2:0] {
    REG_HEALTHY_THR   = 3'd0,
    REG_UNHEALTHY_THR = 3'd1,
    REG_MIN_SAMPLES   = 3'd2,
    REG_ERR_LIMIT     = 3'd3,
    REG_BASE_EJECT    = 3'd4,
    REG_MAX_EJECT     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]  pass_thr;
    logic [7:0]  fail_thr;
    logic [31:0] min_samples;
    logic [15:0] error_rate_limit_q16;
    logic [31:0] base_eject_ms;
    logic [31:0] max_eject_ms;
  } cfg_t;

  // One queued check round, with the error counters already summed.
  typedef struct packed {
    logic [IDX_W-1:0] backend_index;
    logic             probe_ok;
    logic [32:0]      error_sum;
    logic [31:0]      connection_count;
    logic [47:0]      now_ms;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic [1:0] count;
  } q_status_t;

  typedef struct packed {
    logic [7:0]  pass_run;
    logic [7:0]  fail_run;
    logic        healthy;
    logic        ejected;
    logic [32:0] prev_error_sum;
    logic [31:0] prev_connection_count;
    logic [5:0]  tally;
    logic [31:0] last_ejection_ms;
    logic [47:0] deadline_ms;
  } entry_t;

  localparam entry_t RESET_ENTRY = '{
    pass_run: 8'd0, fail_run: 8'd0, healthy: 1'b1, ejected: 1'b0,
    prev_error_sum: 33'd0, prev_connection_count: 32'd0, tally: 6'd0,
    last_ejection_ms: 32'd0, deadline_ms: 48'd0
  };

  typedef enum logic [2:0] {
    S_IDLE, S_CALC, S_RATE, S_LEN, S_WB
  } back_state_t;

endpackage
`default_nettype wire

[hdl/bhoe_front.sv]
// Front end: accepts check rounds, sums error counters and queues them.
`default_nettype none
module bhoe_front (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push,
  input  wire logic [bhoe_pkg::IDX_W-1:0] backend_index,
  input  wire logic                    probe_ok,
  input  wire logic [31:0]             connect_fail_count,
  input  wire logic [31:0]             abnormal_close_count,
  input  wire logic [31:0]             connection_count,
  input  wire logic [47:0]             now_ms,
  input  wire logic                    pop,
  output bhoe_pkg::item_t              head,
  output bhoe_pkg::q_status_t          status
);

  bhoe_pkg::item_t slot_r [2];
  logic wr_ptr_r, wr_ptr_nxt;
  logic rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  bhoe_pkg::item_t new_item;

  always_comb begin
    new_item.backend_index    = backend_index;
    new_item.probe_ok         = probe_ok;
    new_item.error_sum        = {1'b0, connect_fail_count} + {1'b0, abnormal_close_count};
    new_item.connection_count = connection_count;
    new_item.now_ms           = now_ms;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= new_item;
    end
  end

  assign head   = slot_r[rd_ptr_r];
  assign status = '{empty: (count_r == 2'd0), full: (count_r == 2'd2), count: count_r};

endmodule
`default_nettype wire

[hdl/bhoe_back.sv]
// Back end: per-backend state table and the read-modify-write sequencer.
`default_nettype none
module bhoe_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire bhoe_pkg::cfg_t       cfg,
  input  wire bhoe_pkg::item_t      head,
  input  wire bhoe_pkg::q_status_t  q_status,
  output logic                      pop,
  output logic                      res_strobe,
  output logic [bhoe_pkg::IDX_W-1:0] res_index,
  output logic                      res_healthy,
  output logic                      res_ejected,
  output logic                      res_changed,
  output logic [31:0]               res_length
);

  bhoe_pkg::entry_t mem [bhoe_pkg::NUM_BACKENDS];
  logic [bhoe_pkg::NUM_BACKENDS-1:0] valid_r;
  bhoe_pkg::entry_t rd_r;
  logic rd_valid_r;

  bhoe_pkg::back_state_t state_r, state_nxt;
  bhoe_pkg::item_t item_r;
  bhoe_pkg::entry_t ent_r, ent_nxt;
  logic [32:0] d_err_r, d_err_nxt;
  logic [33:0] att_r, att_nxt;
  logic hchg_r, hchg_nxt;
  logic echg_r, echg_nxt;
  logic eject_r, eject_nxt;

  bhoe_pkg::entry_t cur;
  logic [32:0] prev_err;
  logic [31:0] prev_cc, d_tot;
  logic [49:0] limit_prod;
  logic [48:0] err_scaled;
  logic [5:0]  sh;
  logic [62:0] shifted;
  logic wb;

  logic out_strobe_r;
  logic [bhoe_pkg::IDX_W-1:0] out_index_r;
  logic out_healthy_r, out_ejected_r, out_changed_r;
  logic [31:0] out_length_r;

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    wb        = 1'b0;
    ent_nxt   = ent_r;
    d_err_nxt = d_err_r;
    att_nxt   = att_r;
    hchg_nxt  = hchg_r;
    echg_nxt  = echg_r;
    eject_nxt = eject_r;
    cur       = rd_valid_r ? rd_r : bhoe_pkg::RESET_ENTRY;
    prev_err  = rd_valid_r ? rd_r.prev_error_sum : item_r.error_sum;
    prev_cc   = rd_valid_r ? rd_r.prev_connection_count : item_r.connection_count;
    d_tot     = item_r.connection_count - prev_cc;
    limit_prod = {34'd0, cfg.error_rate_limit_q16} * {16'd0, att_r};
    err_scaled = {d_err_r, 16'd0};
    sh         = ent_r.tally - 6'd1;
    shifted    = {31'd0, cfg.base_eject_ms} << sh[4:0];
    unique case (state_r)
      bhoe_pkg::S_IDLE: begin
        if (!q_status.empty) begin
          pop       = 1'b1;
          state_nxt = bhoe_pkg::S_CALC;
        end
      end
      bhoe_pkg::S_CALC: begin
        ent_nxt  = cur;
        hchg_nxt = 1'b0;
        echg_nxt = 1'b0;
        if (item_r.probe_ok) begin
          if (cur.pass_run != 8'hFF) ent_nxt.pass_run = cur.pass_run + 8'd1;
          ent_nxt.fail_run = 8'd0;
          if (!cur.healthy && ent_nxt.pass_run >= cfg.pass_thr) begin
            ent_nxt.healthy = 1'b1;
            hchg_nxt = 1'b1;
          end
        end else begin
          if (cur.fail_run != 8'hFF) ent_nxt.fail_run = cur.fail_run + 8'd1;
          ent_nxt.pass_run = 8'd0;
          if (cur.healthy && ent_nxt.fail_run >= cfg.fail_thr) begin
            ent_nxt.healthy = 1'b0;
            hchg_nxt = 1'b1;
          end
        end
        d_err_nxt = item_r.error_sum - prev_err;
        att_nxt   = {1'b0, d_err_nxt} + {2'b00, d_tot};
        ent_nxt.prev_error_sum        = item_r.error_sum;
        ent_nxt.prev_connection_count = item_r.connection_count;
        state_nxt = bhoe_pkg::S_RATE;
      end
      bhoe_pkg::S_RATE: begin
        eject_nxt = 1'b0;
        if (ent_r.ejected) begin
          if (item_r.now_ms >= ent_r.deadline_ms) begin
            ent_nxt.ejected = 1'b0;
            echg_nxt = 1'b1;
          end
        end else if (att_r >= {2'b00, cfg.min_samples}) begin
          if ({1'b0, err_scaled} > limit_prod) begin
            eject_nxt = 1'b1;
            if (ent_r.tally != 6'd63) ent_nxt.tally = ent_r.tally + 6'd1;
          end
        end
        state_nxt = bhoe_pkg::S_LEN;
      end
      bhoe_pkg::S_LEN: begin
        if (eject_r) begin
          if (cfg.base_eject_ms == 32'd0) begin
            ent_nxt.last_ejection_ms = 32'd0;
          end else if (sh[5]) begin
            ent_nxt.last_ejection_ms = cfg.max_eject_ms;
          end else if (shifted > {31'd0, cfg.max_eject_ms}) begin
            ent_nxt.last_ejection_ms = cfg.max_eject_ms;
          end else begin
            ent_nxt.last_ejection_ms = shifted[31:0];
          end
        end
        state_nxt = bhoe_pkg::S_WB;
      end
      bhoe_pkg::S_WB: begin
        wb = 1'b1;
        if (eject_r) begin
          ent_nxt.deadline_ms = item_r.now_ms + {16'd0, ent_r.last_ejection_ms};
          ent_nxt.ejected     = 1'b1;
          echg_nxt            = 1'b1;
        end
        state_nxt = bhoe_pkg::S_IDLE;
      end
      default: state_nxt = bhoe_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bhoe_pkg::S_IDLE;
      valid_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= wb;
      if (wb) valid_r[item_r.backend_index] <= 1'b1;
    end
  end

  // Table port: one registered read at pop, one write at the end of the round.
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_r       <= mem[head.backend_index];
      rd_valid_r <= valid_r[head.backend_index];
      item_r     <= head;
    end
    if (wb) begin
      mem[item_r.backend_index] <= ent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r   <= ent_nxt;
    d_err_r <= d_err_nxt;
    att_r   <= att_nxt;
    hchg_r  <= hchg_nxt;
    echg_r  <= echg_nxt;
    eject_r <= eject_nxt;
    if (wb) begin
      out_index_r   <= item_r.backend_index;
      out_healthy_r <= ent_nxt.healthy;
      out_ejected_r <= ent_nxt.ejected;
      out_changed_r <= hchg_r | echg_nxt;
      out_length_r  <= ent_nxt.last_ejection_ms;
    end
  end

  assign res_strobe  = out_strobe_r;
  assign res_index   = out_index_r;
  assign res_healthy = out_healthy_r;
  assign res_ejected = out_ejected_r;
  assign res_changed = out_changed_r;
  assign res_length  = out_length_r;

endmodule
`default_nettype wire

[hdl/backend_health_and_outlier_ejection_unit.sv]
// Top level of the backend health and outlier ejection unit.
//
// Usage: a check round is offered on the in_ ports with start; it is taken at
// a rising edge where start is high and busy is low. The front end sums the
// error counters and places the round in a two-entry queue, so busy rises
// only when that queue is full.
// The back end processes one round at a time, in order: a table read, the
// run counters and deltas, the rate test (one 16 x 34 multiply), the
// backoff length, and the table write. It pops no new round from the queue
// until the last one has been written back.
// Each result is shown for exactly one cycle with out_strobe high and cannot
// be stalled by the receiver.
// Reset clears the queue, the sequencer and the per-backend valid bits, so
// every backend reads as healthy with empty history; configuration returns
// to its reset values. Configuration is written through cfg_we, cfg_index and
// cfg_data.
`default_nettype none
module backend_health_and_outlier_ejection_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [5:0]  in_backend_index,
  input  wire logic        in_probe_ok,
  input  wire logic [31:0] in_connect_fail_count,
  input  wire logic [31:0] in_abnormal_close_count,
  input  wire logic [31:0] in_connection_count,
  input  wire logic [47:0] in_now_ms,
  output logic             out_strobe,
  output logic [5:0]       out_result_index,
  output logic             out_is_healthy,
  output logic             out_is_ejected,
  output logic             out_status_changed,
  output logic [31:0]      out_ejection_length_ms,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  bhoe_pkg::cfg_t cfg_r;
  bhoe_pkg::item_t head;
  bhoe_pkg::q_status_t q_status;
  logic push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pass_thr             <= 8'd2;
      cfg_r.fail_thr             <= 8'd3;
      cfg_r.min_samples          <= 32'd10;
      cfg_r.error_rate_limit_q16 <= 16'd32768;
      cfg_r.base_eject_ms        <= 32'd30000;
      cfg_r.max_eject_ms         <= 32'd300000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bhoe_pkg::REG_HEALTHY_THR:   cfg_r.pass_thr             <= cfg_data[7:0];
        bhoe_pkg::REG_UNHEALTHY_THR: cfg_r.fail_thr             <= cfg_data[7:0];
        bhoe_pkg::REG_MIN_SAMPLES:   cfg_r.min_samples          <= cfg_data;
        bhoe_pkg::REG_ERR_LIMIT:     cfg_r.error_rate_limit_q16 <= cfg_data[15:0];
        bhoe_pkg::REG_BASE_EJECT:    cfg_r.base_eject_ms        <= cfg_data;
        bhoe_pkg::REG_MAX_EJECT:     cfg_r.max_eject_ms         <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = q_status.full;
  assign push = start & ~q_status.full;

  bhoe_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .push                 (push),
    .backend_index        (in_backend_index),
    .probe_ok             (in_probe_ok),
    .connect_fail_count   (in_connect_fail_count),
    .abnormal_close_count (in_abnormal_close_count),
    .connection_count     (in_connection_count),
    .now_ms               (in_now_ms),
    .pop                  (pop),
    .head                 (head),
    .status               (q_status)
  );

  bhoe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .head        (head),
    .q_status    (q_status),
    .pop         (pop),
    .res_strobe  (out_strobe),
    .res_index   (out_result_index),
    .res_healthy (out_is_healthy),
    .res_ejected (out_is_ejected),
    .res_changed (out_status_changed),
    .res_length  (out_ejection_length_ms)
  );

`ifndef ASSERT_OFF
  // The sequencer handles one round at a time, so strobes never touch.
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("back-to-back result strobes");

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.count != 2'd3) else $error("queue count overflow");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> !q_status.empty) else $error("accepted transfer lost from queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty) else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

[test/backend_health_and_outlier_ejection_unit_tb.sv]
// Self-checking testbench for the backend health and outlier ejection unit.
`timescale 1ns / 100ps
module backend_health_and_outlier_ejection_unit_tb;

  typedef struct packed {
    logic [5:0]  idx;
    logic        ok;
    logic [31:0] cf;
    logic [31:0] ac;
    logic [31:0] cc;
    logic [47:0] now;
  } round_t;

  typedef struct packed {
    logic [5:0]  idx;
    logic        healthy;
    logic        ejected;
    logic        changed;
    logic [31:0] len;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [5:0] in_backend_index = '0;
  logic in_probe_ok = 1'b0;
  logic [31:0] in_connect_fail_count = '0;
  logic [31:0] in_abnormal_close_count = '0;
  logic [31:0] in_connection_count = '0;
  logic [47:0] in_now_ms = '0;
  logic out_strobe;
  logic [5:0] out_result_index;
  logic out_is_healthy, out_is_ejected, out_status_changed;
  logic [31:0] out_ejection_length_ms;
  logic cfg_we = 1'b0;
  bhoe_pkg::cfg_reg_t cfg_index = bhoe_pkg::REG_HEALTHY_THR;
  logic [31:0] cfg_data = '0;

  backend_health_and_outlier_ejection_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_backend_index(in_backend_index), .in_probe_ok(in_probe_ok),
    .in_connect_fail_count(in_connect_fail_count),
    .in_abnormal_close_count(in_abnormal_close_count),
    .in_connection_count(in_connection_count), .in_now_ms(in_now_ms),
    .out_strobe(out_strobe), .out_result_index(out_result_index),
    .out_is_healthy(out_is_healthy), .out_is_ejected(out_is_ejected),
    .out_status_changed(out_status_changed),
    .out_ejection_length_ms(out_ejection_length_ms),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor copy of the configuration and the backend table.
  bhoe_pkg::cfg_t   cfg_shadow;
  bhoe_pkg::entry_t table_shadow [bhoe_pkg::NUM_BACKENDS];
  logic             seeded [bhoe_pkg::NUM_BACKENDS];

  round_t   pending_rounds[$];
  verdict_t expected_verdicts[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int watchdog = 0;

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  function automatic logic [31:0] backoff_len(input logic [5:0] tally);
    logic [5:0] sh;
    logic [63:0] len;
    sh = tally - 6'd1;
    if (cfg_shadow.base_eject_ms == 0) return 32'd0;
    if (sh >= 6'd32) return cfg_shadow.max_eject_ms;
    len = {32'd0, cfg_shadow.base_eject_ms} << sh;
    if (len > {32'd0, cfg_shadow.max_eject_ms})
      len = {32'd0, cfg_shadow.max_eject_ms};
    return len[31:0];
  endfunction

  function automatic verdict_t judge_round(input round_t r);
    verdict_t v;
    bhoe_pkg::entry_t e;
    logic changed;
    logic [32:0] esum, d_err;
    logic [31:0] d_tot;
    logic [33:0] attempts;
    logic [49:0] scaled_err, scaled_lim;
    e = table_shadow[r.idx];
    changed = 1'b0;
    if (r.ok) begin
      if (e.pass_run != 8'hff) e.pass_run++;
      e.fail_run = 0;
      if (!e.healthy && e.pass_run >= cfg_shadow.pass_thr) begin
        e.healthy = 1'b1;
        changed = 1'b1;
      end
    end else begin
      if (e.fail_run != 8'hff) e.fail_run++;
      e.pass_run = 0;
      if (e.healthy && e.fail_run >= cfg_shadow.fail_thr) begin
        e.healthy = 1'b0;
        changed = 1'b1;
      end
    end
    esum = {1'b0, r.cf} + {1'b0, r.ac};
    if (!seeded[r.idx]) begin
      e.prev_error_sum = esum;
      e.prev_connection_count = r.cc;
      seeded[r.idx] = 1'b1;
    end
    d_err = esum - e.prev_error_sum;
    d_tot = r.cc - e.prev_connection_count;
    e.prev_error_sum = esum;
    e.prev_connection_count = r.cc;
    attempts = {1'b0, d_err} + {2'b0, d_tot};
    if (e.ejected) begin
      if (r.now >= e.deadline_ms) begin
        e.ejected = 1'b0;
        changed = 1'b1;
      end
    end else if (attempts >= {2'b0, cfg_shadow.min_samples}) begin
      scaled_err = {1'b0, d_err, 16'd0};
      scaled_lim = cfg_shadow.error_rate_limit_q16 * attempts;
      if (scaled_err > scaled_lim) begin
        if (e.tally != 6'd63) e.tally++;
        e.last_ejection_ms = backoff_len(e.tally);
        e.deadline_ms = r.now + {16'd0, e.last_ejection_ms};
        e.ejected = 1'b1;
        changed = 1'b1;
      end
    end
    table_shadow[r.idx] = e;
    v.idx = r.idx;
    v.healthy = e.healthy;
    v.ejected = e.ejected;
    v.changed = changed;
    v.len = e.last_ejection_ms;
    return v;
  endfunction

  // Driver: holds start high while rounds remain and the sender is not idling.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_verdicts.push_back(judge_round(pending_rounds.pop_front()));
      end
      if (!start || !busy) begin
        if (pending_rounds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          start <= 1'b1;
          in_backend_index <= pending_rounds[0].idx;
          in_probe_ok <= pending_rounds[0].ok;
          in_connect_fail_count <= pending_rounds[0].cf;
          in_abnormal_close_count <= pending_rounds[0].ac;
          in_connection_count <= pending_rounds[0].cc;
          in_now_ms <= pending_rounds[0].now;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe must match the oldest expectation.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("unexpected result", out_result_index, 0);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_result_index !== want.idx)
            report_mismatch("result_index", out_result_index, want.idx);
          if (out_is_healthy !== want.healthy)
            report_mismatch("is_healthy", out_is_healthy, want.healthy);
          if (out_is_ejected !== want.ejected)
            report_mismatch("is_ejected", out_is_ejected, want.ejected);
          if (out_status_changed !== want.changed)
            report_mismatch("status_changed", out_status_changed, want.changed);
          if (out_ejection_length_ms !== want.len)
            report_mismatch("ejection_length_ms", out_ejection_length_ms, want.len);
        end
      end
      if (out_strobe || (start && !busy)) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (watchdog > 2000) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input bhoe_pkg::cfg_reg_t which, input logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    case (which)
      bhoe_pkg::REG_HEALTHY_THR:   cfg_shadow.pass_thr = value[7:0];
      bhoe_pkg::REG_UNHEALTHY_THR: cfg_shadow.fail_thr = value[7:0];
      bhoe_pkg::REG_MIN_SAMPLES:   cfg_shadow.min_samples = value;
      bhoe_pkg::REG_ERR_LIMIT:     cfg_shadow.error_rate_limit_q16 = value[15:0];
      bhoe_pkg::REG_BASE_EJECT:    cfg_shadow.base_eject_ms = value;
      default:                     cfg_shadow.max_eject_ms = value;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    while (pending_rounds.size() > 0 || start || expected_verdicts.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Random content; most rounds follow a per-backend counter history so that
  // deltas stay in a realistic range and ejections happen often.
  logic [31:0] hist_cf [bhoe_pkg::NUM_BACKENDS];
  logic [31:0] hist_ac [bhoe_pkg::NUM_BACKENDS];
  logic [31:0] hist_cc [bhoe_pkg::NUM_BACKENDS];
  logic [47:0] clock_ms;

  task automatic queue_round(input logic [5:0] idx, input logic ok);
    round_t r;
    int mode;
    mode = $urandom_range(19);
    clock_ms += 48'($urandom_range(2000));
    if (mode == 0) begin
      r.cf = $urandom; r.ac = $urandom; r.cc = $urandom;
      r.now = 48'({$urandom, $urandom});
    end else begin
      hist_cf[idx] += $urandom_range(mode < 8 ? 20 : 2);
      hist_ac[idx] += $urandom_range(mode < 8 ? 20 : 2);
      hist_cc[idx] += $urandom_range(30);
      if (mode == 1) clock_ms += 48'({$urandom_range(3), $urandom});
      r.cf = hist_cf[idx]; r.ac = hist_ac[idx]; r.cc = hist_cc[idx];
      r.now = clock_ms;
    end
    r.idx = idx;
    r.ok = ok;
    pending_rounds.push_back(r);
  endtask

  initial begin
    round_t r;
    int phase, n;
    cfg_shadow = '{8'd2, 8'd3, 32'd10, 16'd32768, 32'd30000, 32'd300000};
    for (int i = 0; i < bhoe_pkg::NUM_BACKENDS; i++) begin
      table_shadow[i] = bhoe_pkg::RESET_ENTRY;
      seeded[i] = 1'b0;
      hist_cf[i] = $urandom; hist_ac[i] = $urandom; hist_cc[i] = $urandom;
    end
    clock_ms = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: counter extremes, wraps, probe runs and backend extremes.
    r = '{6'd0, 1'b0, 32'd0, 32'd0, 32'd0, 48'd0};
    pending_rounds.push_back(r);
    r = '{6'd0, 1'b0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 48'hffffffffffff};
    pending_rounds.push_back(r);
    r = '{6'd0, 1'b0, 32'd5, 32'd5, 32'd2, 48'd10};
    pending_rounds.push_back(r);
    r = '{6'd0, 1'b1, 32'd5, 32'd5, 32'd2, 48'd40010};
    pending_rounds.push_back(r);
    r = '{6'd0, 1'b1, 32'd100, 32'd0, 32'd2, 48'd40011};
    pending_rounds.push_back(r);
    for (int k = 0; k < 6; k++) begin
      r = '{6'd63, 1'b0, 32'd0, 32'd0, 32'd0, 48'd0};
      r.cf = 32'h7fffffff * k; r.ac = 32'hffff0000 + 7 * k;
      r.cc = 32'd3 * k; r.now = 48'h800000000000 + 48'd400000 * k;
      pending_rounds.push_back(r);
    end
    for (int k = 0; k < 4; k++) begin
      r = '{6'd42, 1'b1, 32'd0, 32'd0, 32'd1000 * k, 48'd1};
      pending_rounds.push_back(r);
    end
    drain();

    // Extreme settings first, then mostly random ones, over six phases at three idling levels.
    write_reg(bhoe_pkg::REG_HEALTHY_THR, 32'd1);
    write_reg(bhoe_pkg::REG_UNHEALTHY_THR, 32'd255);
    write_reg(bhoe_pkg::REG_MIN_SAMPLES, 32'd0);
    write_reg(bhoe_pkg::REG_ERR_LIMIT, 32'd0);
    write_reg(bhoe_pkg::REG_BASE_EJECT, 32'hffffffff);
    write_reg(bhoe_pkg::REG_MAX_EJECT, 32'hffffffff);
    for (phase = 0; phase < 6; phase++) begin
      send_idle_pct = phase < 2 ? 35 : (phase < 4 ? 54 : 0);
      if (phase > 0) begin
        write_reg(bhoe_pkg::REG_HEALTHY_THR,
                  phase == 5 ? 32'd255 : $urandom_range(1, 4));
        write_reg(bhoe_pkg::REG_UNHEALTHY_THR,
                  phase == 5 ? 32'd1 : $urandom_range(1, 4));
        write_reg(bhoe_pkg::REG_MIN_SAMPLES,
                  phase == 5 ? 32'hffffffff : $urandom_range(20));
        write_reg(bhoe_pkg::REG_ERR_LIMIT,
                  phase == 3 ? 32'hffff : $urandom_range(65535));
        write_reg(bhoe_pkg::REG_BASE_EJECT,
                  phase == 4 ? 32'd1 : $urandom_range(1, 5000));
        write_reg(bhoe_pkg::REG_MAX_EJECT,
                  phase == 4 ? 32'd1 :
                  ($urandom_range(1) == 1 ? $urandom : $urandom_range(1, 400000)));
      end
      n = 330;
      for (int k = 0; k < n; k++)
        queue_round(6'($urandom_range(k % 3 == 0 ? 63 : 3)), 1'($urandom_range(1)));
      drain();
    end
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

[backend_health_and_outlier_ejection_unit.f]
hdl/bhoe_pkg.sv
hdl/bhoe_front.sv
hdl/bhoe_back.sv
hdl/backend_health_and_outlier_ejection_unit.sv
test/backend_health_and_outlier_ejection_unit_tb.sv
